/* sv/hdpwm_pkg.sv */
`timescale 1ns / 1ps

package hdpwm_pkg;

	typedef enum logic [3:0] {
		REG_DRIVE_ENABLE      = 4'd0,
		REG_DETENT_COUNT      = 4'd1,
		REG_POLE_PAIR_COUNT   = 4'd2,
		REG_DIRECTION_REVERSE = 4'd3,
		REG_ELECTRICAL_OFFSET = 4'd4,
		REG_MAX_DRIVE_RATIO   = 4'd5,
		REG_DETENT_STRENGTH   = 4'd6,
		REG_STRENGTH_SCALE    = 4'd7
	} cfg_reg_t;

	localparam logic [14:0] RATIO_CAP   = 15'd32112;
	localparam logic [15:0] SCALE_MAX   = 16'd32768;
	localparam logic [15:0] GAIN_MAX    = 16'd32768;
	localparam logic [15:0] THIRD_TURN  = 16'd21845;
	localparam logic [16:0] HALF_Q16    = 17'd32768;
	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [31:0] ROUND_Q15   = 32'd16384;

	localparam logic [7:0]  RST_DETENT_COUNT    = 8'd24;
	localparam logic [6:0]  RST_POLE_PAIR_COUNT = 7'd7;
	localparam logic [15:0] RST_DETENT_STRENGTH = 16'd16384;
	localparam logic [15:0] RST_STRENGTH_SCALE  = 16'd32768;

	typedef struct packed {
		logic        drive_enable;
		logic [7:0]  detent_count;
		logic [6:0]  pole_pair_count;
		logic        direction_reverse;
		logic [13:0] electrical_offset;
		logic [14:0] ratio;
		logic [15:0] gain;
	} cfg_t;

	typedef struct packed {
		logic        neg;
		logic [14:0] mag;
	} sine_t;

	localparam logic [14:0] QSINE [33] = '{
		15'd0,     15'd1608,  15'd3212,  15'd4808,  15'd6392,  15'd7962,  15'd9512,
		15'd11039, 15'd12539, 15'd14010, 15'd15446, 15'd16846, 15'd18204, 15'd19519,
		15'd20787, 15'd22005, 15'd23170, 15'd24279, 15'd25329, 15'd26319, 15'd27245,
		15'd28105, 15'd28898, 15'd29621, 15'd30273, 15'd30852, 15'd31356, 15'd31785,
		15'd32137, 15'd32412, 15'd32609, 15'd32728, 15'd32767
	};

	function automatic sine_t sine_lookup(input logic [15:0] phase);
		logic [14:0] x;
		logic [5:0]  idx;
		logic [5:0]  idx_hi;
		logic [8:0]  frac;
		logic [14:0] lo;
		logic [14:0] hi;
		logic [20:0] step;
		sine_t       r;
		x = {1'b0, phase[13:0]};
		if (phase[14]) begin
			x = 15'd16384 - x;
		end
		idx = x[14:9];
		frac = x[8:0];
		idx_hi = (idx < 6'd32) ? idx + 6'd1 : idx;
		lo = QSINE[idx];
		hi = QSINE[idx_hi];
		step = 21'(hi - lo) * 21'(frac) + 21'd256;
		r.neg = phase[15];
		r.mag = lo + 15'(step[20:9]);
		return r;
	endfunction

endpackage

/* sv/hdpwm_cfg.sv */
`timescale 1ns / 1ps

module hdpwm_cfg import hdpwm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	logic        drive_enable_q;
	logic [7:0]  detent_count_q;
	logic [6:0]  pole_pair_count_q;
	logic        direction_reverse_q;
	logic [13:0] electrical_offset_q;
	logic [14:0] max_drive_ratio_q;
	logic [15:0] detent_strength_q;
	logic [15:0] strength_scale_q;
	logic [14:0] ratio_q;
	logic [15:0] gain_q;

	logic [15:0] scale;
	logic [31:0] gain_prod;
	logic [17:0] gain_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_enable_q      <= 1'b0;
			detent_count_q      <= RST_DETENT_COUNT;
			pole_pair_count_q   <= RST_POLE_PAIR_COUNT;
			direction_reverse_q <= 1'b0;
			electrical_offset_q <= '0;
			max_drive_ratio_q   <= '0;
			detent_strength_q   <= RST_DETENT_STRENGTH;
			strength_scale_q    <= RST_STRENGTH_SCALE;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DRIVE_ENABLE:      drive_enable_q      <= cfg_data[0];
				REG_DETENT_COUNT:      detent_count_q      <= cfg_data[7:0];
				REG_POLE_PAIR_COUNT:   pole_pair_count_q   <= cfg_data[6:0];
				REG_DIRECTION_REVERSE: direction_reverse_q <= cfg_data[0];
				REG_ELECTRICAL_OFFSET: electrical_offset_q <= cfg_data[13:0];
				REG_MAX_DRIVE_RATIO:   max_drive_ratio_q   <= cfg_data[14:0];
				REG_DETENT_STRENGTH:   detent_strength_q   <= cfg_data;
				REG_STRENGTH_SCALE:    strength_scale_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign scale     = (strength_scale_q > SCALE_MAX) ? SCALE_MAX : strength_scale_q;
	assign gain_prod = 32'(detent_strength_q) * 32'(scale);
	assign gain_raw  = gain_prod[31:14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_MAX;
			ratio_q <= '0;
		end else begin
			gain_q  <= (gain_raw > 18'(GAIN_MAX)) ? GAIN_MAX : gain_raw[15:0];
			ratio_q <= (max_drive_ratio_q > RATIO_CAP) ? RATIO_CAP : max_drive_ratio_q;
		end
	end

	always_comb begin
		cfg.drive_enable      = drive_enable_q;
		cfg.detent_count      = detent_count_q;
		cfg.pole_pair_count   = pole_pair_count_q;
		cfg.direction_reverse = direction_reverse_q;
		cfg.electrical_offset = electrical_offset_q;
		cfg.ratio             = ratio_q;
		cfg.gain              = gain_q;
	end

endmodule

/* sv/hdpwm_pipe.sv */
`timescale 1ns / 1ps

module hdpwm_pipe import hdpwm_pkg::*; #(
	parameter int DUTY_BITS  = 10,
	parameter int ANGLE_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  angle_valid,
	input  logic [ANGLE_BITS-1:0] rotor_angle,
	input  cfg_t                  cfg,
	output logic                  out_valid,
	output logic [DUTY_BITS-1:0]  duty_u,
	output logic [DUTY_BITS-1:0]  duty_v,
	output logic [DUTY_BITS-1:0]  duty_w,
	output logic                  torque_active
);

	localparam int MECH_SHIFT = 16 - ANGLE_BITS;
	localparam int SCALED_W   = 17 + DUTY_BITS;

	function automatic logic [DUTY_BITS-1:0] to_duty(
		input logic        active,
		input logic        neg,
		input logic [15:0] term
	);
		logic [16:0]         value;
		logic [SCALED_W-1:0] scaled;
		if (!active) begin
			value = HALF_Q16;
		end else if (neg) begin
			value = (17'(term) > HALF_Q16) ? 17'd0 : HALF_Q16 - 17'(term);
		end else begin
			value = (HALF_Q16 + 17'(term) > ONE_Q16) ? ONE_Q16 : HALF_Q16 + 17'(term);
		end
		scaled = (SCALED_W'(value) << DUTY_BITS) - SCALED_W'(value);
		return scaled[16 +: DUTY_BITS];
	endfunction

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic        act_s1, act_s2, act_s3, act_s4, act_s5, act_s6;

	logic [15:0] mech;
	logic [23:0] dprod;
	logic [22:0] eprod;
	logic [15:0] elec_dir;
	logic [15:0] dph_s1;
	logic [15:0] eph_s1;

	sine_t       dsin_s2;
	sine_t       esin_s2 [3];
	logic [15:0] eph_lane [3];

	logic [31:0] tq_prod;
	logic [15:0] tq_s3;
	logic        tneg_s3, tneg_s4;
	sine_t       esin_s3 [3];
	sine_t       esin_s4 [3];

	logic [31:0] amp_prod;
	logic [15:0] amp_s4;

	logic [31:0] term_prod [3];
	logic [15:0] term_s5 [3];
	logic        neg_s5 [3];

	logic [DUTY_BITS-1:0] duty_s6 [3];

	assign mech     = 16'(rotor_angle) << MECH_SHIFT;
	assign dprod    = 24'(mech) * 24'(cfg.detent_count);
	assign eprod    = 23'(mech) * 23'(cfg.pole_pair_count);
	assign elec_dir = cfg.direction_reverse ? 16'd0 - eprod[15:0] : eprod[15:0];

	assign eph_lane[0] = eph_s1;
	assign eph_lane[1] = eph_s1 - THIRD_TURN;
	assign eph_lane[2] = eph_s1 + THIRD_TURN;

	assign tq_prod  = 32'(cfg.gain) * 32'(dsin_s2.mag) + ROUND_Q15;
	assign amp_prod = 32'(cfg.ratio) * 32'(tq_s3) + ROUND_Q15;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			term_prod[i] = 32'(amp_s4) * 32'(esin_s4[i].mag) + ROUND_Q15;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		act_s1 <= angle_valid & cfg.drive_enable;
		dph_s1 <= dprod[15:0];
		eph_s1 <= elec_dir + {cfg.electrical_offset, 2'b00};

		act_s2  <= act_s1;
		dsin_s2 <= sine_lookup(dph_s1);
		for (int i = 0; i < 3; i++) begin
			esin_s2[i] <= sine_lookup(eph_lane[i]);
		end

		act_s3  <= act_s2;
		tq_s3   <= tq_prod[30:15];
		tneg_s3 <= !dsin_s2.neg && (dsin_s2.mag != 15'd0);
		esin_s3 <= esin_s2;

		act_s4  <= act_s3;
		amp_s4  <= amp_prod[30:15];
		tneg_s4 <= tneg_s3;
		esin_s4 <= esin_s3;

		act_s5 <= act_s4;
		for (int i = 0; i < 3; i++) begin
			term_s5[i] <= term_prod[i][30:15];
			neg_s5[i]  <= tneg_s4 != esin_s4[i].neg;
		end

		act_s6 <= act_s5;
		for (int i = 0; i < 3; i++) begin
			duty_s6[i] <= to_duty(act_s5, neg_s5[i], term_s5[i]);
		end
	end

	assign out_valid     = v_s6;
	assign duty_u        = duty_s6[0];
	assign duty_v        = duty_s6[1];
	assign duty_w        = duty_s6[2];
	assign torque_active = act_s6;

endmodule

/* sv/haptic_detent_three_phase_pwm.sv */
`timescale 1ns / 1ps

// Haptic detent drive with sinusoidal three-phase commutation. One angle beat is
// taken in every clock cycle that start is high (busy stays low), and its three
// duties appear on a one-cycle done strobe at the end of the six-stage datapath
// (angle products, sine lookups, gain multiply, ratio multiply, phase multiplies,
// duty scaling). Results cannot be held off, so the receiver must capture every
// done beat. Configuration writes are always ready; write them while no angle is
// in flight. The derived gain and ratio are registered again after the settings.
module haptic_detent_three_phase_pwm import hdpwm_pkg::*; #(
	parameter int DUTY_BITS  = 10,
	parameter int ANGLE_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  angle_valid,
	input  logic [ANGLE_BITS-1:0] rotor_angle,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [3:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	output logic                  done,
	output logic [DUTY_BITS-1:0]  duty_u,
	output logic [DUTY_BITS-1:0]  duty_v,
	output logic [DUTY_BITS-1:0]  duty_w,
	output logic                  torque_active
);

	localparam logic [DUTY_BITS-1:0] MID_DUTY = DUTY_BITS'(((1 << DUTY_BITS) - 1) / 2);

	cfg_t cfg;
	logic accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	hdpwm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hdpwm_pipe #(
		.DUTY_BITS  (DUTY_BITS),
		.ANGLE_BITS (ANGLE_BITS)
	) u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (accept),
		.angle_valid   (angle_valid),
		.rotor_angle   (rotor_angle),
		.cfg           (cfg),
		.out_valid     (done),
		.duty_u        (duty_u),
		.duty_v        (duty_v),
		.duty_w        (duty_w),
		.torque_active (torque_active)
	);

`ifndef SYNTHESIS
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 6))
		else $error("done without a beat accepted six cycles earlier");

	a_neutral_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !torque_active) |->
			(duty_u == MID_DUTY && duty_v == MID_DUTY && duty_w == MID_DUTY))
		else $error("neutral beat not at mid-scale");

	a_invalid_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(!angle_valid, 6)) |-> !torque_active)
		else $error("torque on a beat with an invalid angle");
`endif

endmodule

/* tb/tb_haptic_detent_three_phase_pwm.sv */
`timescale 1ns / 1ps

module tb_haptic_detent_three_phase_pwm;
	import hdpwm_pkg::*;

	localparam int DUTY_BITS     = 10;
	localparam int ANGLE_BITS    = 14;
	localparam int PIPE_DEPTH    = 6;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 20;
	localparam int PHASE_BEATS   = 85;
	localparam int QUIET_PHASE   = 5;
	localparam int HOLD_PHASE    = 11;
	localparam int REPORT_LIMIT  = 10;

	localparam logic [3:0] REG_UNUSED = 4'd8;

	localparam int unsigned DUTY_FULL  = (1 << DUTY_BITS) - 1;
	localparam int unsigned MID_PHASE  = 32768;
	localparam int unsigned FULL_PHASE = 65536;
	localparam int unsigned PHASE_120  = 21845;
	localparam int unsigned DRIVE_CAP  = 32112;
	localparam int unsigned UNITY_Q15  = 32768;
	localparam int unsigned HALF_LSB   = 16384;

	localparam int unsigned SINE_QTR [33] = '{
		0, 1608, 3212, 4808, 6392, 7962, 9512, 11039,
		12539, 14010, 15446, 16846, 18204, 19519, 20787, 22005,
		23170, 24279, 25329, 26319, 27245, 28105, 28898, 29621,
		30273, 30852, 31356, 31785, 32137, 32412, 32609, 32728,
		32767
	};

	typedef struct packed {
		logic [DUTY_BITS-1:0] u;
		logic [DUTY_BITS-1:0] v;
		logic [DUTY_BITS-1:0] w;
		logic                 active;
	} duty_set_t;

	localparam duty_set_t NEUTRAL    = '{10'd511, 10'd511, 10'd511, 1'b0};
	localparam duty_set_t MID_DRIVEN = '{10'd511, 10'd511, 10'd511, 1'b1};

	typedef enum logic {ROW_WRITE, ROW_ANGLE} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [3:0]            idx;
		logic [15:0]           data;
		logic                  valid;
		logic [ANGLE_BITS-1:0] angle;
		bit                    typed;
		duty_set_t             want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  angle_valid;
	logic [ANGLE_BITS-1:0] rotor_angle;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [3:0]            cfg_index;
	logic [15:0]           cfg_data;
	logic                  done;
	logic [DUTY_BITS-1:0]  duty_u;
	logic [DUTY_BITS-1:0]  duty_v;
	logic [DUTY_BITS-1:0]  duty_w;
	logic                  torque_active;

	logic        set_enable    = 1'b0;
	logic [7:0]  set_detents   = RST_DETENT_COUNT;
	logic [6:0]  set_poles     = RST_POLE_PAIR_COUNT;
	logic        set_reverse   = 1'b0;
	logic [13:0] set_offset    = 14'd0;
	logic [14:0] set_ratio     = 15'd0;
	logic [15:0] set_base_gain = RST_DETENT_STRENGTH;
	logic [15:0] set_scale     = RST_STRENGTH_SCALE;

	duty_set_t duties_due [$];
	stim_row_t plan [$];
	bit        gaps_on;
	bit        row_typed;
	duty_set_t row_want;
	int        faults;
	int        cycles;

	haptic_detent_three_phase_pwm #(
		.DUTY_BITS(DUTY_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.angle_valid(angle_valid),
		.rotor_angle(rotor_angle),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.duty_u(duty_u),
		.duty_v(duty_v),
		.duty_w(duty_w),
		.torque_active(torque_active)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned sine_mag_of(input logic [15:0] ph, output logic neg);
		logic [14:0] x;
		int unsigned i;
		int unsigned f;
		int unsigned lo;
		int unsigned hi;
		x = {1'b0, ph[13:0]};
		if (ph[14]) begin
			x = 15'd16384 - x;
		end
		i = x[14:9];
		f = x[8:0];
		lo = SINE_QTR[i];
		hi = (i < 32) ? SINE_QTR[i + 1] : lo;
		neg = ph[15];
		return lo + (((hi - lo) * f + 256) >> 9);
	endfunction

	function automatic int unsigned phase_level(input int unsigned amp, input logic amp_neg,
			input logic [15:0] ph);
		logic        sneg;
		int unsigned s;
		int unsigned term;
		s = sine_mag_of(ph, sneg);
		term = (amp * s + HALF_LSB) >> 15;
		if (amp_neg != sneg) begin
			return (term > MID_PHASE) ? 0 : MID_PHASE - term;
		end
		return (MID_PHASE + term > FULL_PHASE) ? FULL_PHASE : MID_PHASE + term;
	endfunction

	function automatic logic [DUTY_BITS-1:0] duty_of(input int unsigned lvl);
		longint unsigned p;
		p = lvl;
		p = p * DUTY_FULL;
		return DUTY_BITS'(p >> 16);
	endfunction

	function automatic duty_set_t predict_duties(input logic valid,
			input logic [ANGLE_BITS-1:0] angle);
		duty_set_t   r;
		int unsigned mech;
		int unsigned prod;
		int unsigned dsin;
		int unsigned scale;
		int unsigned gain;
		int unsigned tq;
		int unsigned ratio;
		int unsigned amp;
		logic [15:0] elec;
		logic        dneg;
		logic        tneg;
		if (!valid || !set_enable) begin
			r.u = duty_of(MID_PHASE);
			r.v = r.u;
			r.w = r.u;
			r.active = 1'b0;
			return r;
		end
		mech = {angle, 2'b00};
		prod = mech * set_detents;
		dsin = sine_mag_of(prod[15:0], dneg);
		tneg = !dneg && (dsin != 0);
		scale = (set_scale > UNITY_Q15) ? UNITY_Q15 : set_scale;
		gain = (set_base_gain * scale) >> 14;
		if (gain > UNITY_Q15) begin
			gain = UNITY_Q15;
		end
		tq = (gain * dsin + HALF_LSB) >> 15;
		ratio = (set_ratio > DRIVE_CAP) ? DRIVE_CAP : set_ratio;
		amp = (ratio * tq + HALF_LSB) >> 15;
		prod = mech * set_poles;
		elec = prod[15:0];
		if (set_reverse) begin
			elec = 16'(FULL_PHASE - elec);
		end
		elec = elec + {set_offset, 2'b00};
		r.u = duty_of(phase_level(amp, tneg, elec));
		r.v = duty_of(phase_level(amp, tneg, 16'(elec + FULL_PHASE - PHASE_120)));
		r.w = duty_of(phase_level(amp, tneg, 16'(elec + PHASE_120)));
		r.active = 1'b1;
		return r;
	endfunction

	always @(posedge clk) begin
		duty_set_t want;
		duty_set_t got;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("haptic_detent_three_phase_pwm test failed");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				got = '{duty_u, duty_v, duty_w, torque_active};
				if (duties_due.size() == 0) begin
					if (faults < REPORT_LIMIT) begin
						$display("unexpected duty beat: u=%0d v=%0d w=%0d active=%0b",
							got.u, got.v, got.w, got.active);
					end
					faults++;
				end else begin
					want = duties_due.pop_front();
					if (got !== want) begin
						if (faults < REPORT_LIMIT) begin
							$display("mismatch: want %0d %0d %0d %0b, got %0d %0d %0d %0b",
								want.u, want.v, want.w, want.active,
								got.u, got.v, got.w, got.active);
						end
						faults++;
					end
				end
			end
			if (start && !busy) begin
				duties_due.push_back(row_typed ? row_want : predict_duties(angle_valid, rotor_angle));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DRIVE_ENABLE:      set_enable = cfg_data[0];
					REG_DETENT_COUNT:      set_detents = cfg_data[7:0];
					REG_POLE_PAIR_COUNT:   set_poles = cfg_data[6:0];
					REG_DIRECTION_REVERSE: set_reverse = cfg_data[0];
					REG_ELECTRICAL_OFFSET: set_offset = cfg_data[13:0];
					REG_MAX_DRIVE_RATIO:   set_ratio = cfg_data[14:0];
					REG_DETENT_STRENGTH:   set_base_gain = cfg_data;
					REG_STRENGTH_SCALE:    set_scale = cfg_data;
					default: ;
				endcase
			end
		end
	end

	function automatic void add_write(input logic [3:0] idx, input logic [15:0] data);
		plan.push_back('{ROW_WRITE, idx, data, 1'b0, '0, 1'b0, '0});
	endfunction

	function automatic void add_angle(input logic valid, input logic [ANGLE_BITS-1:0] angle);
		plan.push_back('{ROW_ANGLE, 4'd0, 16'd0, valid, angle, 1'b0, '0});
	endfunction

	function automatic void add_typed(input logic valid, input logic [ANGLE_BITS-1:0] angle,
			input duty_set_t want);
		plan.push_back('{ROW_ANGLE, 4'd0, 16'd0, valid, angle, 1'b1, want});
	endfunction

	function automatic logic [15:0] pick_value(input int unsigned lo, input int unsigned hi);
		case ($urandom_range(0, 9))
			0: return 16'(lo);
			1: return 16'(hi);
			2: return 16'($urandom);
			default: return 16'($urandom_range(lo, hi));
		endcase
	endfunction

	function automatic logic [ANGLE_BITS-1:0] pick_angle();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return ANGLE_BITS'($urandom);
		endcase
	endfunction

	task automatic send_angle(input logic valid, input logic [ANGLE_BITS-1:0] angle,
			input bit typed, input duty_set_t want);
		while (gaps_on && $urandom_range(0, 99) < 33) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		angle_valid <= valid;
		rotor_angle <= angle;
		row_typed <= typed;
		row_want <= want;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// hold off until the gain and ratio derived from the new settings are in place
	task automatic end_writes();
		cfg_valid <= 1'b0;
		repeat (2) @(negedge clk);
	endtask

	task automatic wait_idle(input bit settle);
		start <= 1'b0;
		do @(negedge clk); while (duties_due.size() != 0);
		if (settle) begin
			repeat (PIPE_DEPTH + 2) @(negedge clk);
		end
	endtask

	task automatic write_random_setup();
		write_reg(REG_DRIVE_ENABLE, {15'($urandom), 1'($urandom_range(0, 7) != 0)});
		write_reg(REG_DETENT_COUNT, pick_value(0, 255));
		write_reg(REG_POLE_PAIR_COUNT, pick_value(0, 127));
		write_reg(REG_DIRECTION_REVERSE, 16'($urandom));
		write_reg(REG_ELECTRICAL_OFFSET, pick_value(0, 16383));
		write_reg(REG_MAX_DRIVE_RATIO, pick_value(0, 32767));
		write_reg(REG_DETENT_STRENGTH, pick_value(0, 65535));
		write_reg(REG_STRENGTH_SCALE, pick_value(0, 32768));
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_UNUSED | 4'($urandom_range(0, 7)), 16'($urandom));
		end
	endtask

	initial begin
		row_kind_t prev_kind;
		arst_n = 1'b0;
		start = 1'b0;
		angle_valid = 1'b0;
		rotor_angle = '0;
		cfg_valid = 1'b0;
		cfg_index = 4'd0;
		cfg_data = 16'd0;
		gaps_on = 1'b1;
		row_typed = 1'b0;
		row_want = '0;
		faults = 0;
		cycles = 0;

		add_typed(1'b1, 14'd0, NEUTRAL);
		add_typed(1'b1, 14'h3FFF, NEUTRAL);
		add_typed(1'b0, 14'd8192, NEUTRAL);
		add_write(REG_DRIVE_ENABLE, 16'd1);
		add_typed(1'b1, 14'd1234, MID_DRIVEN);
		add_typed(1'b0, 14'h3FFF, NEUTRAL);
		add_write(REG_MAX_DRIVE_RATIO, 16'hFFFF);
		add_write(REG_STRENGTH_SCALE, 16'hFFFF);
		add_write(REG_DETENT_STRENGTH, 16'hFFFF);
		add_typed(1'b1, 14'd0, MID_DRIVEN);
		add_angle(1'b1, 14'h3FFF);
		add_angle(1'b1, 14'd170);
		add_angle(1'b1, 14'd512);
		add_angle(1'b1, 14'd8192);
		add_write(REG_DIRECTION_REVERSE, 16'hFFFF);
		add_write(REG_ELECTRICAL_OFFSET, 16'hFFFF);
		add_write(REG_POLE_PAIR_COUNT, 16'hFFFF);
		add_write(REG_DETENT_COUNT, 16'hFFFF);
		add_write(REG_UNUSED, 16'hFFFF);
		add_angle(1'b1, 14'h3FFF);
		add_angle(1'b1, 14'd5461);
		add_angle(1'b1, 14'd100);
		add_write(REG_POLE_PAIR_COUNT, 16'd0);
		add_write(REG_DETENT_COUNT, 16'd0);
		add_typed(1'b1, 14'd9999, MID_DRIVEN);
		add_write(REG_DETENT_COUNT, 16'd1);
		add_write(REG_STRENGTH_SCALE, 16'd0);
		add_typed(1'b1, 14'd4096, MID_DRIVEN);
		add_write(REG_STRENGTH_SCALE, 16'd32768);
		add_write(REG_DETENT_STRENGTH, 16'd16384);
		add_write(REG_MAX_DRIVE_RATIO, 16'd32112);
		add_write(REG_DIRECTION_REVERSE, 16'd0);
		add_write(REG_ELECTRICAL_OFFSET, 16'd0);
		add_write(REG_POLE_PAIR_COUNT, 16'd1);
		add_angle(1'b1, 14'd12288);
		add_angle(1'b1, 14'd4096);
		add_write(REG_DRIVE_ENABLE, 16'd0);
		add_typed(1'b1, 14'd777, NEUTRAL);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		prev_kind = ROW_ANGLE;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (prev_kind == ROW_ANGLE) begin
					wait_idle(1'b1);
				end
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				if (prev_kind == ROW_WRITE) begin
					end_writes();
				end
				send_angle(plan[i].valid, plan[i].angle, plan[i].typed, plan[i].want);
			end
			prev_kind = plan[i].kind;
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle(1'b1);
			write_random_setup();
			end_writes();
			gaps_on = (ph != QUIET_PHASE);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (ph == HOLD_PHASE && n == PHASE_BEATS / 2) begin
					wait_idle(1'b0);
				end
				send_angle($urandom_range(0, 9) != 0, pick_angle(), 1'b0, '0);
			end
		end

		wait_idle(1'b1);
		if (faults == 0 && duties_due.size() == 0) begin
			$display("haptic_detent_three_phase_pwm test passed");
		end else begin
			$display("haptic_detent_three_phase_pwm test failed");
		end
		$finish;
	end

endmodule
